[rtl/tma_pkg.sv]
// Shared types and codes for the token mutual-exclusion arbiter.
// Used by the top level, the wait queue and the port checker; no dependencies.
package tma_pkg;

    // Event actions.
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_ENTERED     = 3'd0;
    localparam logic [2:0] ST_GOT_TOKEN   = 3'd1;
    localparam logic [2:0] ST_QUEUED      = 3'd2;
    localparam logic [2:0] ST_REPEAT      = 3'd3;
    localparam logic [2:0] ST_PASSED      = 3'd4;
    localparam logic [2:0] ST_KEPT        = 3'd5;
    localparam logic [2:0] ST_NOT_EXEC    = 3'd6;
    localparam logic [2:0] ST_BAD_SITE    = 3'd7;

    // Register map and reset values.
    localparam logic [1:0] ADDR_ACTIVE_SITES  = 2'b00;
    localparam logic [4:0] ACTIVE_SITES_RESET = 5'd16;

    // Largest value the queue count field can show.
    localparam logic [3:0] QUEUE_COUNT_MAX = 4'd15;

    // One event word.
    typedef struct packed {
        logic       action;
        logic [3:0] site;
    } tma_evt_t;

    // One result word.
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] holder_site;
        logic       granted;
        logic [3:0] granted_site;
        logic [3:0] queue_count;
    } tma_res_t;

    // Commands to the wait queue.
    typedef struct packed {
        logic push;
        logic pop;
    } tma_fifo_ctl_t;

endpackage

[rtl/tma_wait_fifo.sv]
// Circular queue of sites waiting for the token, held in a small memory.
// Depends on tma_pkg for the command struct.
module tma_wait_fifo #(
    parameter int DEPTH = 16,
    parameter int SW    = 4,
    parameter int LW    = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tma_pkg::tma_fifo_ctl_t ctl,
    input  logic [SW-1:0]          push_site,
    output logic [SW-1:0]          head_site,
    output logic [LW-1:0]          level,
    output logic [LW-1:0]          level_next
);

    localparam logic [SW-1:0] LAST_PTR = SW'(DEPTH - 1);

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] head_reg;
    logic [SW-1:0] head_next;
    logic [SW-1:0] tail_reg;
    logic [SW-1:0] tail_next;
    logic [LW-1:0] level_reg;
    logic [SW-1:0] head_rd_reg;
    logic          bypass_reg;
    logic [SW-1:0] bypass_data_reg;
    logic          push_ok;
    logic          pop_ok;

    // A push into a full queue is dropped; a pop needs a waiting site.
    assign push_ok = ctl.push && (level_reg < LW'(DEPTH));
    assign pop_ok  = ctl.pop && (level_reg != '0);

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop_ok)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + SW'(1);
        end
        if (push_ok)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + SW'(1);
        end
    end

    always_comb
    begin
        level_next = level_reg;
        if (push_ok && !pop_ok)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    // Pointer and level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            level_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            level_reg  <= level_next;
            bypass_reg <= push_ok && (tail_reg == head_next);
        end
    end

    // Memory write at the tail and registered read of the next head entry.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_reg] <= push_site;
        end
        head_rd_reg     <= mem[head_next];
        bypass_data_reg <= push_site;
    end

    // A site written into an empty queue is taken from the bypass register.
    assign head_site = bypass_reg ? bypass_data_reg : head_rd_reg;
    assign level     = level_reg;

endmodule

[rtl/token_mutex_arbiter.sv]
// Token-based mutual exclusion arbiter: top level with event decision and state.
// Depends on tma_pkg and tma_wait_fifo.
//
// Each event word (request or release from one site) is taken into an input register,
// where the request and served counts of that site are also read from their memories.
// Once the result register has room, one decision stage reads the token state, updates it and
// loads the result register, which raises the result valid; a result word that is not taken
// is held in that register until the result side takes it.
// One event is accepted per clock as long as the result side keeps taking words;
// the rate is set by that single decision stage, which must finish one event's state update
// before it decides the next. The count memories need no clearing pass: a valid bit per
// entry makes an unwritten count read as zero.
module token_mutex_arbiter #(
    parameter int MAX_SITES   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_ready,
    input  tma_pkg::tma_evt_t evt,
    output logic              res_valid,
    input  logic              res_ready,
    output tma_pkg::tma_res_t res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW    = $clog2(MAX_SITES);
    localparam int LW    = $clog2(MAX_SITES + 1);
    localparam int LIM_W = (LW > 5) ? LW : 5;

    // Configuration register.
    logic [4:0] active_reg;

    // Input stage.
    logic                   a_valid_reg;
    tma_pkg::tma_evt_t      a_evt_reg;
    logic [COUNT_WIDTH-1:0] a_req_cnt_reg;
    logic [COUNT_WIDTH-1:0] a_srv_cnt_reg;

    // Token state.
    logic [SW-1:0]        holder_reg;
    logic [SW-1:0]        holder_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [MAX_SITES-1:0] requesting_reg;
    logic [MAX_SITES-1:0] requesting_next;
    logic [MAX_SITES-1:0] req_vld_reg;
    logic [MAX_SITES-1:0] srv_vld_reg;
    logic [COUNT_WIDTH-1:0] req_mem [MAX_SITES];
    logic [COUNT_WIDTH-1:0] srv_mem [MAX_SITES];

    // Result stage.
    logic              res_valid_reg;
    tma_pkg::tma_res_t res_reg;

    // Decision signals.
    logic                   evt_accept;
    logic                   advance;
    logic [SW-1:0]          rd_idx;
    logic [SW-1:0]          sidx;
    logic [LIM_W-1:0]       act_wide;
    logic [LIM_W-1:0]       lim;
    logic                   bad_site;
    logic                   is_holder;
    logic                   exec_s;
    logic                   fresh;
    logic                   req_we;
    logic                   srv_we;
    logic [COUNT_WIDTH-1:0] req_wdata;
    logic [COUNT_WIDTH-1:0] srv_inc;
    logic                   push_cond;
    logic                   pop_cond;
    logic [2:0]             status;
    logic                   granted;
    logic [SW-1:0]          gsite;
    tma_pkg::tma_fifo_ctl_t fifo_ctl;
    logic [SW-1:0]          head_site;
    logic [LW-1:0]          fifo_level;
    logic [LW-1:0]          fifo_level_next;
    tma_pkg::tma_res_t      res_next;

    // Handshakes: the input register moves on when the result register has room.
    assign advance    = a_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready  = !a_valid_reg || advance;
    assign evt_accept = evt_valid && evt_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == tma_pkg::ADDR_ACTIVE_SITES) ? 32'(active_reg) : '0;

    // Number of sites in use, clamped to the legal range.
    assign act_wide = LIM_W'(active_reg);
    always_comb
    begin
        priority if (act_wide < LIM_W'(2))
        begin
            lim = LIM_W'(2);
        end
        else if (act_wide > LIM_W'(MAX_SITES))
        begin
            lim = LIM_W'(MAX_SITES);
        end
        else
        begin
            lim = act_wide;
        end
    end

    // Only the holder can be executing, so one busy bit stands for all executing flags.
    assign rd_idx    = SW'(evt.site);
    assign sidx      = SW'(a_evt_reg.site);
    assign bad_site  = LIM_W'(a_evt_reg.site) >= lim;
    assign is_holder = (holder_reg == sidx);
    assign exec_s    = is_holder && busy_reg;
    assign req_wdata = a_req_cnt_reg + COUNT_WIDTH'(1);
    assign srv_inc   = a_srv_cnt_reg + COUNT_WIDTH'(1);
    assign fresh     = (srv_inc == req_wdata);

    // Event decision.
    always_comb
    begin
        holder_next     = holder_reg;
        busy_next       = busy_reg;
        requesting_next = requesting_reg;
        req_we          = 1'b0;
        srv_we          = 1'b0;
        push_cond       = 1'b0;
        pop_cond        = 1'b0;
        status          = tma_pkg::ST_BAD_SITE;
        granted         = 1'b0;
        gsite           = '0;
        priority if (bad_site)
        begin
            status = tma_pkg::ST_BAD_SITE;
        end
        else if (a_evt_reg.action == tma_pkg::ACT_REQUEST)
        begin
            priority if (requesting_reg[sidx] || exec_s)
            begin
                status = tma_pkg::ST_REPEAT;
            end
            else if (is_holder)
            begin
                req_we    = 1'b1;
                busy_next = 1'b1;
                status    = tma_pkg::ST_ENTERED;
                granted   = 1'b1;
                gsite     = sidx;
            end
            else if (fresh && !busy_reg)
            begin
                req_we      = 1'b1;
                holder_next = sidx;
                busy_next   = 1'b1;
                status      = tma_pkg::ST_GOT_TOKEN;
                granted     = 1'b1;
                gsite       = sidx;
            end
            else
            begin
                // A stale request is marked but never queued.
                req_we                = 1'b1;
                requesting_next[sidx] = 1'b1;
                push_cond             = fresh;
                status                = tma_pkg::ST_QUEUED;
            end
        end
        else
        begin
            priority if (!exec_s)
            begin
                status = tma_pkg::ST_NOT_EXEC;
            end
            else if (fifo_level != '0)
            begin
                srv_we                     = 1'b1;
                pop_cond                   = 1'b1;
                holder_next                = head_site;
                busy_next                  = 1'b1;
                requesting_next[head_site] = 1'b0;
                status                     = tma_pkg::ST_PASSED;
                granted                    = 1'b1;
                gsite                      = head_site;
            end
            else
            begin
                srv_we    = 1'b1;
                busy_next = 1'b0;
                status    = tma_pkg::ST_KEPT;
            end
        end
    end

    assign fifo_ctl.push = advance && push_cond;
    assign fifo_ctl.pop  = advance && pop_cond;

    tma_wait_fifo #(
        .DEPTH (MAX_SITES),
        .SW    (SW),
        .LW    (LW)
    ) u_wait_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (fifo_ctl),
        .push_site  (sidx),
        .head_site  (head_site),
        .level      (fifo_level),
        .level_next (fifo_level_next)
    );

    // Result word.
    always_comb
    begin
        res_next.status       = status;
        res_next.holder_site  = 4'(holder_next);
        res_next.granted      = granted;
        res_next.granted_site = 4'(gsite);
        res_next.queue_count  = (fifo_level_next > LW'(tma_pkg::QUEUE_COUNT_MAX))
                                ? tma_pkg::QUEUE_COUNT_MAX : 4'(fifo_level_next);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= tma_pkg::ACTIVE_SITES_RESET;
            a_valid_reg    <= 1'b0;
            holder_reg     <= '0;
            busy_reg       <= 1'b0;
            requesting_reg <= '0;
            req_vld_reg    <= '0;
            srv_vld_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr == tma_pkg::ADDR_ACTIVE_SITES))
            begin
                active_reg <= pwdata[4:0];
            end
            if (evt_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                holder_reg     <= holder_next;
                busy_reg       <= busy_next;
                requesting_reg <= requesting_next;
                if (req_we)
                begin
                    req_vld_reg[sidx] <= 1'b1;
                end
                if (srv_we)
                begin
                    srv_vld_reg[sidx] <= 1'b1;
                end
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Count memories, input stage payload and result payload.
    always_ff @(posedge clk)
    begin
        if (advance && req_we)
        begin
            req_mem[sidx] <= req_wdata;
        end
        if (advance && srv_we)
        begin
            srv_mem[sidx] <= a_req_cnt_reg;
        end
        if (evt_accept)
        begin
            a_evt_reg <= evt;
            // Forward a count written by the event leaving the input stage.
            if (advance && req_we && (sidx == rd_idx))
            begin
                a_req_cnt_reg <= req_wdata;
            end
            else
            begin
                a_req_cnt_reg <= req_vld_reg[rd_idx] ? req_mem[rd_idx] : '0;
            end
            if (advance && srv_we && (sidx == rd_idx))
            begin
                a_srv_cnt_reg <= a_req_cnt_reg;
            end
            else
            begin
                a_srv_cnt_reg <= srv_vld_reg[rd_idx] ? srv_mem[rd_idx] : '0;
            end
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/tma_checker.sv]
// Port checker for the token mutual-exclusion arbiter, bound to the top level.
// Depends on tma_pkg for the status codes and the result word type.
module tma_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input tma_pkg::tma_res_t res
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res))
        else $error("result word changed while stalled");

    // A grant is reported exactly for the entering, token and passing codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.granted == ((res.status == tma_pkg::ST_ENTERED) ||
                                       (res.status == tma_pkg::ST_GOT_TOKEN) ||
                                       (res.status == tma_pkg::ST_PASSED))))
        else $error("grant flag does not match status");

    // The site that enters always ends up holding the token.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.granted |-> (res.holder_site == res.granted_site))
        else $error("granted site is not the token holder");

    // Without a grant the granted site reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.granted |-> (res.granted_site == 4'd0))
        else $error("granted site set without a grant");

endmodule

bind token_mutex_arbiter tma_checker u_tma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

[tb/tb_token_mutex_arbiter.sv]
// Self-checking testbench for token_mutex_arbiter: directed and random request/release words.
// Holds its own token bookkeeping and checks every result word; depends on tma_pkg.
`timescale 1ns / 100ps

// Tracks the token, the per-site flags and counts and the wait queue, predicts one
// result word per accepted event word and compares it with what the block returns.
class token_tracker;
    localparam int SITES = 16;

    logic [4:0]  active_sites;
    logic [3:0]  holder;
    bit          executing [SITES];
    bit          requesting[SITES];
    logic [15:0] req_count   [SITES];
    logic [15:0] served_count[SITES];
    int unsigned waiters[$];
    tma_pkg::tma_res_t outcomes[$];

    int errors;
    int events_seen;
    int results_seen;
    int status_hits[8];

    function new();
        active_sites = tma_pkg::ACTIVE_SITES_RESET;
        holder = '0;
        for (int i = 0; i < SITES; i++)
        begin
            executing[i]    = 1'b0;
            requesting[i]   = 1'b0;
            req_count[i]    = '0;
            served_count[i] = '0;
        end
    endfunction

    function void set_active_sites(logic [4:0] value);
        active_sites = value;
    endfunction

    // The register is clamped to the range the block supports.
    function int sites_in_use();
        int n;
        n = int'(active_sites);
        if (n < 2)
            n = 2;
        if (n > SITES)
            n = SITES;
        return n;
    endfunction

    // Apply one event to the token state and return the result word it should give.
    function tma_pkg::tma_res_t resolve_event(tma_pkg::tma_evt_t e);
        tma_pkg::tma_res_t r;
        int                s;
        int unsigned       nxt;
        logic [15:0]       next_served;
        bit                fresh;
        r = '0;
        s = int'(e.site);
        if (s >= sites_in_use())
        begin
            r.status = tma_pkg::ST_BAD_SITE;
        end
        else if (e.action == tma_pkg::ACT_REQUEST)
        begin
            if (requesting[s] || executing[s])
            begin
                r.status = tma_pkg::ST_REPEAT;
            end
            else
            begin
                req_count[s] = req_count[s] + 16'd1;
                if (holder == 4'(s))
                begin
                    executing[s]   = 1'b1;
                    r.status       = tma_pkg::ST_ENTERED;
                    r.granted      = 1'b1;
                    r.granted_site = 4'(s);
                end
                else
                begin
                    next_served = served_count[s] + 16'd1;
                    fresh = (next_served == req_count[s]);
                    if (fresh && !executing[holder])
                    begin
                        holder         = 4'(s);
                        executing[s]   = 1'b1;
                        r.status       = tma_pkg::ST_GOT_TOKEN;
                        r.granted      = 1'b1;
                        r.granted_site = 4'(s);
                    end
                    else
                    begin
                        // A stale request is marked but never joins the queue.
                        requesting[s] = 1'b1;
                        if (fresh && waiters.size() < SITES)
                            waiters.push_back(s);
                        r.status = tma_pkg::ST_QUEUED;
                    end
                end
            end
        end
        else
        begin
            if (!executing[s])
            begin
                r.status = tma_pkg::ST_NOT_EXEC;
            end
            else
            begin
                served_count[s] = req_count[s];
                executing[s] = 1'b0;
                if (waiters.size() != 0)
                begin
                    nxt = waiters.pop_front();
                    holder = 4'(nxt);
                    executing[nxt]  = 1'b1;
                    requesting[nxt] = 1'b0;
                    r.status       = tma_pkg::ST_PASSED;
                    r.granted      = 1'b1;
                    r.granted_site = 4'(nxt);
                end
                else
                begin
                    r.status = tma_pkg::ST_KEPT;
                end
            end
        end
        r.holder_site = holder;
        r.queue_count = (waiters.size() > 15) ? tma_pkg::QUEUE_COUNT_MAX : 4'(waiters.size());
        return r;
    endfunction

    function void note_event(tma_pkg::tma_evt_t e);
        tma_pkg::tma_res_t want;
        want = resolve_event(e);
        status_hits[want.status]++;
        events_seen++;
        outcomes.push_back(want);
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task compare_field(string name, int got, int want);
        if (got != want)
            report($sformatf("result %0d field %s: got %0d, expected %0d",
                             results_seen, name, got, want));
    endtask

    task check_outcome(tma_pkg::tma_res_t got);
        tma_pkg::tma_res_t want;
        results_seen++;
        if (outcomes.size() == 0)
        begin
            report($sformatf("result %0d arrived with nothing expected (word %h)",
                             results_seen, got));
        end
        else
        begin
            want = outcomes.pop_front();
            compare_field("status",       int'(got.status),       int'(want.status));
            compare_field("holder_site",  int'(got.holder_site),  int'(want.holder_site));
            compare_field("granted",      int'(got.granted),      int'(want.granted));
            compare_field("granted_site", int'(got.granted_site), int'(want.granted_site));
            compare_field("queue_count",  int'(got.queue_count),  int'(want.queue_count));
        end
    endtask

    task check_drained();
        if (outcomes.size() != 0)
            report($sformatf("%0d expected results never arrived", outcomes.size()));
    endtask
endclass

module tb_token_mutex_arbiter;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 115;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              evt_valid;
    logic              evt_ready;
    tma_pkg::tma_evt_t evt;
    logic              res_valid;
    logic              res_ready;
    tma_pkg::tma_res_t res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    token_tracker tracker = new();
    bit           calm;
    int           cycles;
    int           settings_used;

    // Site counts per random phase, the register extremes among them, and how often
    // the holder lets go in each phase (low values let the wait queue fill up).
    int phase_sites  [PHASES] = '{16, 2, 31, 0, 1, 9, 17, 5, 3, 16};
    int phase_release[PHASES] = '{30, 50, 20, 45, 15, 60, 25, 40, 35, 30};

    token_mutex_arbiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Watch both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && evt_valid && evt_ready)
            tracker.note_event(evt);
        if (rst_n && res_valid && res_ready)
            tracker.check_outcome(res);
    end

    // The result side stalls at random except during the calm stretch.
    always @(negedge clk)
    begin
        res_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic tma_pkg::tma_evt_t event_of(logic action, int site);
        tma_pkg::tma_evt_t e;
        e.action = action;
        e.site   = 4'(site);
        return e;
    endfunction

    // Mostly well-formed traffic: idle sites ask for the token and the executing
    // holder lets it go; about one word in ten is arbitrary noise.
    function automatic tma_pkg::tma_evt_t pick_event(int release_pct);
        tma_pkg::tma_evt_t e;
        int                n;
        int                s;
        bit                can_release;
        n = tracker.sites_in_use();
        can_release = tracker.executing[tracker.holder] && (int'(tracker.holder) < n);
        if ($urandom_range(0, 99) < 10)
            return event_of(1'($urandom_range(0, 1)), $urandom_range(0, 15));
        if (can_release && $urandom_range(0, 99) < release_pct)
            return event_of(tma_pkg::ACT_RELEASE, int'(tracker.holder));
        for (int tries = 0; tries < 8; tries++)
        begin
            s = $urandom_range(0, n - 1);
            if (!tracker.requesting[s] && !tracker.executing[s])
                return event_of(tma_pkg::ACT_REQUEST, s);
        end
        if (can_release)
            e = event_of(tma_pkg::ACT_RELEASE, int'(tracker.holder));
        else
            e = event_of(tma_pkg::ACT_REQUEST, $urandom_range(0, n - 1));
        return e;
    endfunction

    // Present one word, with random gaps in front of it, and wait until it is taken.
    task automatic send_event(tma_pkg::tma_evt_t e);
        while (!calm && $urandom_range(0, 99) < 32)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= e;
        do
            @(posedge clk);
        while (!evt_ready);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_idle();
        evt_valid <= 1'b0;
        while (tracker.outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Two-phase register write; upper data bits carry junk that must be ignored.
    task automatic write_active_sites(logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tma_pkg::ADDR_ACTIVE_SITES;
        pwdata  <= {27'($urandom_range(0, 32'h07FF_FFFF)), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.set_active_sites(value);
        settings_used++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        evt_valid <= 1'b0;
        evt       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        calm      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset site count: release without holding, the holder
        // entering, repeated requests, every other site queued, a release by a non-holder, then a hand-over.
        send_event(event_of(tma_pkg::ACT_RELEASE, 0));
        send_event(event_of(tma_pkg::ACT_REQUEST, 0));
        send_event(event_of(tma_pkg::ACT_REQUEST, 0));
        for (int s = 1; s < 16; s++)
            send_event(event_of(tma_pkg::ACT_REQUEST, s));
        send_event(event_of(tma_pkg::ACT_REQUEST, 15));
        send_event(event_of(tma_pkg::ACT_RELEASE, 5));
        send_event(event_of(tma_pkg::ACT_RELEASE, 0));

        // Shrink to two sites while most of them still wait: the queued sites keep
        // their place and the token may land beyond the new count.
        wait_idle();
        write_active_sites(5'd2);
        send_event(event_of(tma_pkg::ACT_REQUEST, 15));
        send_event(event_of(tma_pkg::ACT_RELEASE, 1));
        send_event(event_of(tma_pkg::ACT_RELEASE, 2));
        send_event(event_of(tma_pkg::ACT_REQUEST, 1));

        // Random phases, each at its own site count; one phase runs with no idling.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_active_sites(5'(phase_sites[p]));
            calm = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_event(pick_event(phase_release[p]));
        end

        calm = 1'b0;
        wait_idle();
        repeat (20) @(negedge clk);
        tracker.check_drained();

        $display("Ran %0d event words, checked %0d result words, %0d site-count settings.",
                 tracker.events_seen, tracker.results_seen, settings_used);
        $display("Status mix: entered %0d, got token %0d, queued %0d, repeat %0d, ",
                 tracker.status_hits[tma_pkg::ST_ENTERED],
                 tracker.status_hits[tma_pkg::ST_GOT_TOKEN],
                 tracker.status_hits[tma_pkg::ST_QUEUED],
                 tracker.status_hits[tma_pkg::ST_REPEAT],
                 "passed %0d, kept %0d, not executing %0d, bad site %0d.",
                 tracker.status_hits[tma_pkg::ST_PASSED],
                 tracker.status_hits[tma_pkg::ST_KEPT],
                 tracker.status_hits[tma_pkg::ST_NOT_EXEC],
                 tracker.status_hits[tma_pkg::ST_BAD_SITE]);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
